// File: rtl/core/aiq_pkg.sv
// shared types and constants for the absmax int8 quantizer
`default_nettype none

package aiq_pkg;

    // float32 constants
    localparam logic [31:0] C_F127     = 32'h42FE_0000;
    localparam logic [31:0] C_F1       = 32'h3F80_0000;
    localparam logic [30:0] C_TINY_MAG = 31'h2B8C_BCCC;

    // item and job codes
    localparam logic OP_MEASURE  = 1'b0;
    localparam logic OP_QUANTIZE = 1'b1;
    localparam logic KIND_SCALE  = 1'b0;
    localparam logic KIND_QUANT  = 1'b1;

    // job queue sizing
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // divider step count: 24 mantissa bits plus guard
    localparam int DIV_STEPS = 25;
    localparam int DCNT_W    = 5;

    // one job from the front to the back
    typedef struct packed {
        logic        kind;   // scale job or quantize job
        logic [31:0] data;   // amax bits or element bits
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_QRND,
        BK_DIVA,
        BK_DIVB,
        BK_SOUT
    } bk_state_t;

endpackage

`default_nettype wire

// File: rtl/core/aiq_front.sv
// front end: tracks the running maximum and turns quantize beats and each tlast measure beat into jobs
`default_nettype none

module aiq_front
    import aiq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             job_valid,
    output job_t             job,
    input  wire logic        job_ready
);

    logic [30:0] max_reg;
    logic [30:0] max_next;
    logic [30:0] max_join;
    logic [30:0] mag;
    logic        finite;
    logic        accept;

    assign s_axis_tready = job_ready;
    assign accept        = s_axis_tvalid & job_ready;
    assign mag           = s_axis_tdata[30:0];
    assign finite        = (s_axis_tdata[30:23] != 8'hFF);

    // fold this element into the maximum
    assign max_join = (finite && (mag > max_reg)) ? mag : max_reg;

    // job build and maximum update
    always_comb
    begin
        max_next  = max_reg;
        job_valid = 1'b0;
        job.kind  = KIND_QUANT;
        job.data  = s_axis_tdata;
        if (accept)
        begin
            if (s_axis_tuser == OP_QUANTIZE)
            begin
                job_valid = 1'b1;
            end
            else if (s_axis_tlast)
            begin
                job_valid = 1'b1;
                job.kind  = KIND_SCALE;
                job.data  = (max_join < C_TINY_MAG) ? C_F1 : {1'b0, max_join};
                max_next  = '0;
            end
            else
            begin
                max_next = max_join;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
        end
        else
        begin
            max_reg <= max_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/aiq_queue.sv
// short job queue between front and back
`default_nettype none

module aiq_queue
    import aiq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  job_t      in_job,
    output logic      in_ready,
    output logic      out_valid,
    output job_t      out_job,
    input  wire logic out_ready
);

    job_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_reg;
    logic [QPTR_W-1:0]  rd_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_job   = mem_reg[rd_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/aiq_back.sv
// back end: quantize multiply-round and the scale divider
`default_nettype none

module aiq_back
    import aiq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    input  job_t             job,
    output logic             job_ready,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tuser
);

    bk_state_t          state_reg, state_next;
    logic [31:0]        inv_reg, inv_next;
    logic [47:0]        prod_reg, prod_next;
    logic signed [9:0]  qexp_reg, qexp_next;
    logic               qneg_reg, qneg_next;
    logic               qnz_reg, qnz_next;
    logic [25:0]        rem_reg, rem_next;
    logic [23:0]        den_reg, den_next;
    logic [24:0]        quo_reg, quo_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic [9:0]         dexp_reg, dexp_next;
    logic [31:0]        amax_reg, amax_next;
    logic [31:0]        scale_reg, scale_next;
    logic               ov_reg, ov_next;
    logic               okind_reg, okind_next;
    logic [31:0]        oscale_reg, oscale_next;
    logic [7:0]         oq_reg, oq_next;

    logic               out_free;

    // divider setup
    logic [31:0]        su_num, su_den;
    logic [23:0]        su_ma, su_mb;
    logic               su_lt;
    logic [25:0]        su_rem;
    logic [9:0]         su_exp;

    // divider step and rounding
    logic               d_ge;
    logic [25:0]        d_sub;
    logic [24:0]        d_quo;
    logic               d_up;
    logic [24:0]        d_sum;
    logic [9:0]         d_exp;
    logic [31:0]        d_res;

    // quantize rounding
    logic               r_hi;
    logic [23:0]        r_mant;
    logic               r_guard;
    logic               r_sticky;
    logic [24:0]        r_sum;
    logic [23:0]        r_m;
    logic signed [9:0]  r_e;
    logic [4:0]         r_sh;
    logic [24:0]        r_ext;
    logic [8:0]         r_t;
    logic [6:0]         r_mag;
    logic [6:0]         r_abs;
    logic [7:0]         r_q;

    // quantize multiply inputs
    logic signed [9:0]  m_ev;
    logic signed [9:0]  m_ei;

    assign out_free      = !ov_reg || m_axis_tready;
    assign job_ready     = (state_reg == BK_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tdata  = {oq_reg, oscale_reg};

    // divider operand selection: amax/127 first, then 127/amax
    always_comb
    begin
        if (state_reg == BK_IDLE)
        begin
            su_num = job.data;
            su_den = C_F127;
        end
        else
        begin
            su_num = C_F127;
            su_den = amax_reg;
        end
        su_ma  = {1'b1, su_num[22:0]};
        su_mb  = {1'b1, su_den[22:0]};
        su_lt  = (su_ma < su_mb);
        su_rem = su_lt ? {1'b0, su_ma, 1'b0} : {2'b00, su_ma};
        su_exp = {2'b00, su_num[30:23]} - {2'b00, su_den[30:23]} + 10'd127
                 - {9'd0, su_lt};
    end

    // one restoring step and the final round to nearest even
    always_comb
    begin
        d_ge  = (rem_reg >= {2'b00, den_reg});
        d_sub = d_ge ? (rem_reg - {2'b00, den_reg}) : rem_reg;
        d_quo = {quo_reg[23:0], d_ge};
        d_up  = d_quo[0] & ((d_sub != '0) | d_quo[1]);
        d_sum = {1'b0, d_quo[24:1]} + {24'd0, d_up};
        d_exp = dexp_reg + {9'd0, d_sum[24]};
        d_res = {1'b0, d_exp[7:0], d_sum[24] ? 23'd0 : d_sum[22:0]};
    end

    // product exponents for the multiply stage
    assign m_ev = signed'({2'b00, job.data[30:23]});
    assign m_ei = signed'({2'b00, inv_reg[30:23]});

    // float round of the product, then round half away and clamp
    always_comb
    begin
        r_hi     = prod_reg[47];
        r_mant   = r_hi ? prod_reg[47:24] : prod_reg[46:23];
        r_guard  = r_hi ? prod_reg[23] : prod_reg[22];
        r_sticky = r_hi ? (prod_reg[22:0] != '0) : (prod_reg[21:0] != '0);
        r_sum    = {1'b0, r_mant} + {24'd0, r_guard & (r_sticky | r_mant[0])};
        r_m      = r_sum[24] ? 24'h80_0000 : r_sum[23:0];
        r_e      = qexp_reg + signed'({9'd0, r_hi}) + signed'({9'd0, r_sum[24]});
        r_sh     = 5'(10'sd23 - r_e);
        r_ext    = {r_m, 1'b0} >> r_sh;
        r_t      = {1'b0, r_ext[8:1]} + {8'd0, r_ext[0]};
        r_mag    = (r_t > 9'd127) ? 7'd127 : r_t[6:0];
        if (!qnz_reg || (r_e <= -10'sd2))
        begin
            r_abs = 7'd0;
        end
        else if (r_e >= 10'sd7)
        begin
            r_abs = 7'd127;
        end
        else
        begin
            r_abs = r_mag;
        end
        r_q = qneg_reg ? (8'd0 - {1'b0, r_abs}) : {1'b0, r_abs};
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        inv_next    = inv_reg;
        prod_next   = prod_reg;
        qexp_next   = qexp_reg;
        qneg_next   = qneg_reg;
        qnz_next    = qnz_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        dexp_next   = dexp_reg;
        amax_next   = amax_reg;
        scale_next  = scale_reg;
        ov_next     = ov_reg & ~m_axis_tready;
        okind_next  = okind_reg;
        oscale_next = oscale_reg;
        oq_next     = oq_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.kind == KIND_QUANT)
                    begin
                        prod_next  = {24'd0, 1'b1, job.data[22:0]}
                                     * {24'd0, 1'b1, inv_reg[22:0]};
                        qexp_next  = m_ev + m_ei - 10'sd254;
                        qneg_next  = job.data[31];
                        qnz_next   = (job.data[30:23] != 8'h00)
                                     && (job.data[30:23] != 8'hFF);
                        state_next = BK_QRND;
                    end
                    else
                    begin
                        amax_next  = job.data;
                        rem_next   = su_rem;
                        den_next   = su_mb;
                        dexp_next  = su_exp;
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = BK_DIVA;
                    end
                end
            end
            BK_QRND:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = KIND_QUANT;
                    oscale_next = '0;
                    oq_next     = r_q;
                    state_next  = BK_IDLE;
                end
            end
            BK_DIVA:
            begin
                rem_next = {d_sub[24:0], 1'b0};
                quo_next = d_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    scale_next = d_res;
                    rem_next   = su_rem;
                    den_next   = su_mb;
                    dexp_next  = su_exp;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = BK_DIVB;
                end
            end
            BK_DIVB:
            begin
                rem_next = {d_sub[24:0], 1'b0};
                quo_next = d_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    inv_next   = d_res;
                    state_next = BK_SOUT;
                end
            end
            BK_SOUT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = KIND_SCALE;
                    oscale_next = scale_reg;
                    oq_next     = '0;
                    state_next  = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control and stored factor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            inv_reg   <= C_F127;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            inv_reg   <= inv_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        qexp_reg   <= qexp_next;
        qneg_reg   <= qneg_next;
        qnz_reg    <= qnz_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        dexp_reg   <= dexp_next;
        amax_reg   <= amax_next;
        scale_reg  <= scale_next;
        okind_reg  <= okind_next;
        oscale_reg <= oscale_next;
        oq_reg     <= oq_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/absmax_int8_quantizer.sv
// top level of the symmetric absmax int8 quantizer
//
// Measure beats (tuser 0) are taken by the front end while the job queue has
// room; it keeps the largest finite magnitude, and the beat marked tlast also
// queues a scale job. In the back end a quantize beat (tuser 1) goes through a
// 24x24 mantissa multiply into a product register, then is rounded to float,
// rounded half away from zero and clamped to +-127. A scale job runs the shared
// restoring divider twice, 25 steps each (amax/127, then 127/amax); quantize
// beats behind it wait in the two-entry job queue and pick up the new factor.
// The result is held in an output register; while it waits the back end holds
// before writing its next result, and input beats are taken only until the
// two-entry job queue is full.
`default_nettype none

module absmax_int8_quantizer
    import aiq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value_bits
    input  wire logic        s_axis_tuser,   // opcode
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // scale_bits, quant_value
    output logic             m_axis_tuser    // kind
);

    logic fq_valid, fq_ready;
    job_t fq_job;
    logic qb_valid, qb_ready;
    job_t qb_job;

    // measure and classify
    aiq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .job_valid     (fq_valid),
        .job           (fq_job),
        .job_ready     (fq_ready)
    );

    // job queue
    aiq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_job    (fq_job),
        .in_ready  (fq_ready),
        .out_valid (qb_valid),
        .out_job   (qb_job),
        .out_ready (qb_ready)
    );

    // execute
    aiq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (qb_valid),
        .job           (qb_job),
        .job_ready     (qb_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/core/aiq_checker.sv
// port-level checks for the quantizer, bound to the top level
`default_nettype none

module aiq_checker
    import aiq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // quantize beats carry no scale bits
    a_qscale: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_QUANT) |-> m_axis_tdata[31:0] == 32'd0)
        else $error("quantize beat with scale bits");

    // quantize beats never reach -128
    a_qrange: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_QUANT) |-> m_axis_tdata[39:32] != 8'h80)
        else $error("quantized value out of range");

    // scale beats carry a zero quant field and a positive normal scale
    a_scale: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_SCALE) |-> m_axis_tdata[39:31] == 9'd0
        && m_axis_tdata[30:23] != 8'h00 && m_axis_tdata[30:23] != 8'hFF)
        else $error("malformed scale beat");

endmodule

bind absmax_int8_quantizer aiq_checker u_aiq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
